/* design/ddd_pkg.sv */
package ddd_pkg;

	localparam int unsigned YEAR_W      = 14;
	localparam int unsigned MONTH_W     = 4;
	localparam int unsigned DAY_W       = 5;
	localparam int unsigned COUNT_W     = 22;
	localparam int unsigned ACC_W       = 25;
	localparam int unsigned TERM_W      = 23;
	localparam int unsigned CUM_W       = 9;
	localparam int unsigned MAX_YEAR_DEF = 9999;
	localparam int unsigned CENTURY     = 100;
	localparam int unsigned YEAR_DAYS   = 365;
	localparam int unsigned MONTHS      = 12;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [YEAR_W-1:0]  first_year;
		logic [MONTH_W-1:0] first_month;
		logic [DAY_W-1:0]   first_day;
		logic [YEAR_W-1:0]  second_year;
		logic [MONTH_W-1:0] second_month;
		logic [DAY_W-1:0]   second_day;
	} dates_t;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic               bad_month;
	} result_t;

	localparam logic [CUM_W-1:0] CUM_COMMON [MONTHS] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	localparam logic [CUM_W-1:0] CUM_LEAP [MONTHS] = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
	};

	function automatic logic [CUM_W-1:0] cum_days(input logic leap,
			input logic [MONTH_W-1:0] month);
		logic [MONTH_W-1:0] idx;
		idx = month - MONTH_W'(1);
		if (idx >= MONTH_W'(MONTHS)) begin
			cum_days = '0;
		end else if (leap) begin
			cum_days = CUM_LEAP[idx];
		end else begin
			cum_days = CUM_COMMON[idx];
		end
	endfunction

	function automatic logic month_ok(input logic [MONTH_W-1:0] month);
		month_ok = (month != '0) && (month <= MONTH_W'(MONTHS));
	endfunction

endpackage

/* design/date_difference_days.sv */
// Sequence: for an accepted dates word, each date's year less one is divided
// by 100 through a reciprocal (quotient, then remainder), then one term and one add;
// a last term and add cover the whole years. One word is worked on at a time,
// and dates_ready is high only while the sequencer is idle.
// Reset: arst_n clears the sequencer and the result valid at once.
module date_difference_days
	import ddd_pkg::*;
#(
	parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    dates_valid,
	output logic    dates_ready,
	input  dates_t  dates,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int unsigned DIV_STEPS = 2;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
	localparam int unsigned REM_W     = $clog2(CENTURY);
	localparam int unsigned RECIP_W   = 15;
	localparam int unsigned DIV_SHIFT = 21;
	localparam int unsigned PROD_W    = YEAR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 15'd20972;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_TERM = 5'b00100,
		ST_ACC  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		PH_OLD   = 2'd0,
		PH_NEW   = 2'd1,
		PH_YEARS = 2'd2
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic   result_valid_q;
	logic [CNT_W-1:0] cnt_q;

	logic [YEAR_W-1:0]  oy_q, ny_q, diff_q, div_q, quo_q;
	logic [MONTH_W-1:0] om_q, nm_q;
	logic [DAY_W-1:0]   od_q, nd_q;
	logic [REM_W-1:0]   rem_q;
	logic               bad_q;
	logic [TERM_W-1:0]  term_q;
	logic signed [ACC_W-1:0] acc_q;
	result_t            result_q;

	logic [YEAR_W-1:0]  y1, y2, cur_y, cur_m1, start_m;
	logic [MONTH_W-1:0] cur_mon;
	logic [DAY_W-1:0]   cur_day;
	logic               swap, bad_in, leap;
	logic [PROD_W-1:0]  prod;
	logic [YEAR_W-1:0]  quo_next;
	logic [REM_W-1:0]   rem_next;
	logic [YEAR_W:0]    leaps;
	logic [TERM_W-1:0]  date_term;
	logic [COUNT_W-1:0] clamped;

	function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
		if ({3'b000, y} > (YEAR_W+3)'(MAX_YEAR)) begin
			clamp_year = YEAR_W'(MAX_YEAR);
		end else begin
			clamp_year = y;
		end
	endfunction

	always_comb begin
		y1 = clamp_year(dates.first_year);
		y2 = clamp_year(dates.second_year);
		bad_in = !month_ok(dates.first_month) || !month_ok(dates.second_month);
		if (y1 != y2) begin
			swap = y1 > y2;
		end else if (dates.first_month != dates.second_month) begin
			swap = dates.first_month > dates.second_month;
		end else begin
			swap = dates.first_day > dates.second_day;
		end
		start_m = (swap ? y2 : y1) - YEAR_W'(1);
	end

	always_comb begin
		cur_y   = (phase_q == PH_OLD) ? oy_q : ny_q;
		cur_mon = (phase_q == PH_OLD) ? om_q : nm_q;
		cur_day = (phase_q == PH_OLD) ? od_q : nd_q;
		cur_m1  = cur_y - YEAR_W'(1);
		prod     = PROD_W'(div_q) * PROD_W'(DIV_RECIP);
		quo_next = YEAR_W'(prod >> DIV_SHIFT);
		rem_next = REM_W'(div_q - YEAR_W'(quo_q * YEAR_W'(CENTURY)));
		if (cur_y == '0) begin
			leaps = '0;
			leap  = 1'b1;
		end else begin
			leaps = (YEAR_W+1)'(cur_m1 >> 2) - (YEAR_W+1)'(quo_q)
				+ (YEAR_W+1)'(quo_q >> 2) + (YEAR_W+1)'(1);
			leap  = (cur_m1[1:0] == 2'b11)
				&& ((rem_q != REM_W'(CENTURY - 1)) || (quo_q[1:0] == 2'b11));
		end
		date_term = TERM_W'(leaps) + TERM_W'(cum_days(leap, cur_mon))
			+ TERM_W'(cur_day);
		if (acc_q < 0) begin
			clamped = '0;
		end else if (acc_q > $signed({{(ACC_W-COUNT_W){1'b0}}, COUNT_MAX})) begin
			clamped = COUNT_MAX;
		end else begin
			clamped = acc_q[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= PH_OLD;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (dates_valid) begin
						phase_q <= PH_OLD;
						cnt_q   <= '0;
						state_q <= bad_in ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					cnt_q <= '0;
					unique case (phase_q)
						PH_OLD: begin
							phase_q <= PH_NEW;
							state_q <= ST_DIV;
						end
						PH_NEW: begin
							phase_q <= PH_YEARS;
							state_q <= ST_TERM;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: begin
					if (!result_valid_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (dates_valid) begin
					oy_q   <= swap ? y2 : y1;
					ny_q   <= swap ? y1 : y2;
					om_q   <= swap ? dates.second_month : dates.first_month;
					nm_q   <= swap ? dates.first_month : dates.second_month;
					od_q   <= swap ? dates.second_day : dates.first_day;
					nd_q   <= swap ? dates.first_day : dates.second_day;
					diff_q <= swap ? (y1 - y2) : (y2 - y1);
					bad_q  <= bad_in;
					div_q  <= start_m;
					rem_q  <= '0;
					quo_q  <= '0;
					acc_q  <= '0;
				end
			end
			ST_DIV: begin
				// divide by 100 through the reciprocal, then take the remainder
				if (cnt_q == '0) begin
					quo_q <= quo_next;
				end else begin
					rem_q <= rem_next;
				end
			end
			ST_TERM: begin
				if (phase_q == PH_YEARS) begin
					term_q <= TERM_W'(diff_q) * TERM_W'(YEAR_DAYS);
				end else begin
					term_q <= date_term;
				end
			end
			ST_ACC: begin
				if (phase_q == PH_OLD) begin
					acc_q <= acc_q - $signed({2'b00, term_q});
				end else begin
					acc_q <= acc_q + $signed({2'b00, term_q});
				end
				if (phase_q == PH_OLD) begin
					div_q <= ny_q - YEAR_W'(1);
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					result_q.day_count <= bad_q ? '0 : clamped;
					result_q.bad_month <= bad_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign dates_ready  = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* dv/tb_top.sv */
module tb_top;
	import ddd_pkg::*;

	localparam int unsigned ITEMS          = 1000;
	localparam int unsigned CALM_FROM      = 850;
	localparam int unsigned YEAR_FIELD_MAX = (1 << YEAR_W) - 1;
	localparam int unsigned DRAIN_CYCLES   = 40;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    dates_valid  = 1'b0;
	dates_t  dates        = '0;
	logic    result_ready = 1'b0;
	logic    dates_ready;
	logic    result_valid;
	result_t result;

	bit calm = 1'b0;

	class day_count_board;
		result_t pending_counts[$];
		int      errors;

		function bit leap_year(int unsigned y);
			return ((y % 4 == 0) && (y % CENTURY != 0)) || (y % 400 == 0);
		endfunction

		function longint leap_years_before(int unsigned n);
			longint m;
			if (n == 0) begin
				return 0;
			end
			m = longint'(n) - 1;
			return m / 4 - m / CENTURY + m / 400 + 1;
		endfunction

		function longint day_in_year(int unsigned y, int unsigned m, int unsigned d);
			longint start;
			case (m)
				1: begin
					start = 0;
				end
				2: begin
					start = 31;
				end
				3: begin
					start = 59;
				end
				4: begin
					start = 90;
				end
				5: begin
					start = 120;
				end
				6: begin
					start = 151;
				end
				7: begin
					start = 181;
				end
				8: begin
					start = 212;
				end
				9: begin
					start = 243;
				end
				10: begin
					start = 273;
				end
				11: begin
					start = 304;
				end
				default: begin
					start = 334;
				end
			endcase
			if (leap_year(y) && m > 2) begin
				start = start + 1;
			end
			return start + longint'(d);
		endfunction

		function int unsigned clamped_year(logic [YEAR_W-1:0] y);
			if (int'(y) > MAX_YEAR_DEF) begin
				return MAX_YEAR_DEF;
			end
			return int'(y);
		endfunction

		function result_t days_between(dates_t w);
			int unsigned y1, m1, d1, y2, m2, d2;
			int unsigned oy, om, od, ny, nm, nd;
			bit          swap;
			longint      total;
			result_t     r;
			y1 = clamped_year(w.first_year);
			m1 = int'(w.first_month);
			d1 = int'(w.first_day);
			y2 = clamped_year(w.second_year);
			m2 = int'(w.second_month);
			d2 = int'(w.second_day);
			r = '0;
			if (m1 < 1 || m1 > MONTHS || m2 < 1 || m2 > MONTHS) begin
				r.bad_month = 1'b1;
				return r;
			end
			if (y1 != y2) begin
				swap = y1 > y2;
			end else if (m1 != m2) begin
				swap = m1 > m2;
			end else begin
				swap = d1 > d2;
			end
			if (swap) begin
				oy = y2; om = m2; od = d2;
				ny = y1; nm = m1; nd = d1;
			end else begin
				oy = y1; om = m1; od = d1;
				ny = y2; nm = m2; nd = d2;
			end
			total = YEAR_DAYS * (longint'(ny) - longint'(oy))
				+ leap_years_before(ny) - leap_years_before(oy)
				+ day_in_year(ny, nm, nd) - day_in_year(oy, om, od);
			if (total < 0) begin
				total = 0;
			end
			if (total > longint'(COUNT_MAX)) begin
				total = longint'(COUNT_MAX);
			end
			r.day_count = COUNT_W'(total);
			return r;
		endfunction

		function void note_dates(dates_t w);
			pending_counts.push_back(days_between(w));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_counts.size() == 0) begin
				$display("%0t: result word with nothing pending: day_count %0d bad_month %0b",
					$time, got.day_count, got.bad_month);
				errors++;
				return;
			end
			want = pending_counts.pop_front();
			if (got.day_count !== want.day_count) begin
				$display("%0t: day_count expected %0d actual %0d",
					$time, want.day_count, got.day_count);
				errors++;
			end
			if (got.bad_month !== want.bad_month) begin
				$display("%0t: bad_month expected %0b actual %0b",
					$time, want.bad_month, got.bad_month);
				errors++;
			end
		endfunction

		function void flush_leftover();
			foreach (pending_counts[i]) begin
				$display("%0t: result word never arrived: day_count %0d bad_month %0b",
					$time, pending_counts[i].day_count, pending_counts[i].bad_month);
			end
			errors += pending_counts.size();
		endfunction
	endclass

	day_count_board board;

	date_difference_days i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.dates_valid  (dates_valid),
		.dates_ready  (dates_ready),
		.dates        (dates),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic dates_t make_dates(int unsigned y1, int unsigned m1, int unsigned d1,
			int unsigned y2, int unsigned m2, int unsigned d2);
		dates_t w;
		w.first_year   = YEAR_W'(y1);
		w.first_month  = MONTH_W'(m1);
		w.first_day    = DAY_W'(d1);
		w.second_year  = YEAR_W'(y2);
		w.second_month = MONTH_W'(m2);
		w.second_day   = DAY_W'(d2);
		return w;
	endfunction

	function automatic dates_t random_dates();
		int unsigned kind;
		int          y1, y2;
		int unsigned m1, m2;
		kind = $urandom_range(0, 19);
		m1 = $urandom_range(1, MONTHS);
		m2 = $urandom_range(1, MONTHS);
		if (kind < 5) begin
			y1 = $urandom_range(0, YEAR_FIELD_MAX);
			y2 = $urandom_range(0, YEAR_FIELD_MAX);
		end else if (kind < 12) begin
			y1 = $urandom_range(0, MAX_YEAR_DEF + 50);
			y2 = y1 + int'($urandom_range(0, 6)) - 3;
			if (y2 < 0) begin
				y2 = 0;
			end
		end else if (kind < 16) begin
			y1 = $urandom_range(0, MAX_YEAR_DEF);
			y2 = y1;
			m2 = (m1 < MONTHS && $urandom_range(0, 1)) ? m1 + 1 : m1;
		end else if (kind < 18) begin
			y1 = $urandom_range(0, 2400);
			y2 = y1;
			m2 = m1;
		end else begin
			y1 = $urandom_range(0, YEAR_FIELD_MAX);
			y2 = $urandom_range(0, YEAR_FIELD_MAX);
			m1 = $urandom_range(0, (1 << MONTH_W) - 1);
			m2 = $urandom_range(0, (1 << MONTH_W) - 1);
		end
		return make_dates(y1, m1, $urandom_range(0, 31), y2, m2, $urandom_range(0, 31));
	endfunction

	task automatic send_dates(input dates_t w);
		int unsigned gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap != 0) begin
			dates_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		dates_valid <= 1'b1;
		dates       <= w;
		do @(posedge clk); while (!dates_ready);
		board.note_dates(w);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			board.check_result(result);
		end
	end

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_dates(make_dates(2020, 6, 15, 2020, 6, 15));
		send_dates(make_dates(0, 1, 1, 1, 1, 1));
		send_dates(make_dates(1, 1, 1, 9999, 12, 31));
		send_dates(make_dates(9999, 12, 31, 0, 1, 0));
		send_dates(make_dates(YEAR_FIELD_MAX, 12, 31, 0, 1, 1));
		send_dates(make_dates(10000, 3, 1, 9999, 3, 1));
		send_dates(make_dates(2000, 0, 1, 2001, 1, 1));
		send_dates(make_dates(2000, 1, 1, 2001, 13, 1));
		send_dates(make_dates(2000, 15, 31, 2001, 0, 0));
		send_dates(make_dates(2000, 12, 1, 2000, 1, 1));
		send_dates(make_dates(2001, 2, 31, 2001, 3, 1));
		send_dates(make_dates(2001, 4, 31, 2001, 5, 1));
		send_dates(make_dates(1900, 2, 28, 1900, 3, 1));
		send_dates(make_dates(2000, 2, 28, 2000, 3, 1));
		send_dates(make_dates(2100, 3, 1, 2100, 2, 28));
		send_dates(make_dates(1600, 1, 1, 1700, 1, 1));
		send_dates(make_dates(2024, 5, 31, 2024, 5, 0));
		send_dates(make_dates(2024, 5, 0, 2024, 5, 31));
		send_dates(make_dates(1999, 12, 31, 2000, 1, 1));
		send_dates(make_dates(5461, 10, 21, 10922, 5, 10));
		send_dates(make_dates(YEAR_FIELD_MAX, 15, 31, YEAR_FIELD_MAX, 15, 31));

		for (int unsigned i = 0; i < ITEMS; i++) begin
			calm = (i >= CALM_FROM) || ((i / 100) % 3 == 1);
			send_dates(random_dates());
		end
		dates_valid <= 1'b0;

		while (board.pending_counts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.flush_leftover();
		if (board.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
design/ddd_pkg.sv
design/date_difference_days.sv
dv/tb_top.sv
